### src/msfc_pkg.sv
package msfc_pkg;

  // Default depth of the queue between classifier and solver
  localparam int QUEUE_DEPTH = 4;

  // Solver iteration counts
  localparam int SQ_BITS = 51;  // root bits of the discriminant
  localparam int K_BITS  = 17;  // bits of the radius ratio, Q1.16 up to 1.0
  localparam int DV_BITS = 17;  // time quotient bits kept before clamping

  localparam logic [15:0] TMAX_RESET = 16'd256;

  typedef enum logic [2:0] {
    REG_CX, REG_CY, REG_CZ, REG_RAD, REG_VX, REG_VY, REG_VZ, REG_TMAX
  } cfg_reg_t;

  typedef enum logic [1:0] {
    K_MISS, K_OVER, K_MOVE
  } kind_t;

  typedef struct packed {
    logic signed [23:0] cand_center_x;
    logic signed [23:0] cand_center_y;
    logic signed [23:0] cand_center_z;
    logic        [22:0] cand_radius;
    logic signed [23:0] cand_vel_x;
    logic signed [23:0] cand_vel_y;
    logic signed [23:0] cand_vel_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic        [15:0] contact_time;
    logic signed [23:0] contact_x;
    logic signed [23:0] contact_y;
    logic signed [23:0] contact_z;
  } out_item_t;

  typedef struct packed {
    logic [2:0][23:0] c0;
    logic [22:0]      r0;
    logic [2:0][23:0] v0;
    logic [15:0]      tmax;
  } cfg_t;

  // Classified pair, one queue word
  typedef struct packed {
    kind_t            kind;
    logic [49:0]      ub;
    logic [49:0]      a;
    logic [100:0]     disc;
    logic [2:0][24:0] e;
    logic [2:0][24:0] d;
    logic [2:0][23:0] mid;
    logic [23:0]      rs;
  } cls_t;

endpackage

### src/msfc_front.sv
module msfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  msfc_pkg::in_item_t in_data,
  input  msfc_pkg::cfg_t    cfg,
  output logic              push,
  output msfc_pkg::cls_t    push_data,
  input  logic              q_full
);
  import msfc_pkg::*;

  typedef struct packed {
    logic [2:0][24:0] e;
    logic [2:0][24:0] d;
    logic [2:0][23:0] mid;
    logic [23:0]      rs;
  } s1_t;

  typedef struct packed {
    logic [2:0][49:0] ee;
    logic [2:0][49:0] dd;
    logic [2:0][49:0] ed;
    logic [47:0]      rr;
    s1_t              g;
  } s2_t;

  typedef struct packed {
    logic [49:0] a;
    logic [49:0] c;
    logic [47:0] r;
    logic [49:0] ub;
    logic [49:0] dpos;
    logic        cle;
    logic        mv;
    logic [31:0] tt;
    s1_t         g;
  } s3_t;

  typedef struct packed {
    logic [40:0] ta_l, ta_h;
    logic [56:0] tta_l, tta_h;
    logic [40:0] tu_l, tu_h;
    logic [49:0] bb_hh, bb_hl, bb_ll;
    logic [49:0] ac_hh, ac_hl, ac_lh, ac_ll;
    logic [49:0] a;
    logic [49:0] c;
    logic [47:0] r;
    logic [49:0] ub;
    logic        cle;
    logic        mv;
    s1_t         g;
  } s4_t;

  typedef struct packed {
    logic [65:0]  ta;
    logic [81:0]  tta;
    logic [65:0]  tu;
    logic [100:0] bb;
    logic [100:0] ac;
    logic [49:0]  a;
    logic [49:0]  c;
    logic [47:0]  r;
    logic [49:0]  ub;
    logic         cle;
    logic         mv;
    s1_t          g;
  } s5_t;

  typedef struct packed {
    logic         reach1;
    logic [83:0]  lhs;
    logic [83:0]  rhs;
    logic         acle;
    logic [100:0] disc;
    logic [49:0]  a;
    logic [49:0]  ub;
    logic         cle;
    logic         mv;
    s1_t          g;
  } s6_t;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  s5_t  s5_r, s5_nxt;
  s6_t  s6_r, s6_nxt;
  cls_t s7_r, s7_nxt;
  logic [6:0] v_r;
  logic       en;

  logic [2:0][23:0]   cen1;
  logic [2:0][23:0]   vel1;
  logic signed [24:0] sum_c [3];
  logic signed [24:0] ev [3];
  logic signed [24:0] dv [3];
  logic signed [49:0] pee [3];
  logic signed [49:0] pdd [3];
  logic signed [49:0] ped [3];
  logic signed [50:0] bsum;
  logic signed [50:0] nb;
  logic [50:0]        ac_mid;
  logic               reach2;

  assign en       = !(v_r[6] && q_full);
  assign in_stall = !en;
  assign push     = v_r[6] && !q_full;
  assign push_data = s7_r;

  assign cen1 = {in_data.cand_center_z, in_data.cand_center_y, in_data.cand_center_x};
  assign vel1 = {in_data.cand_vel_z, in_data.cand_vel_y, in_data.cand_vel_x};

  // Offsets, relative velocity, radius sum, centre midpoint
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_nxt.e[i] = 25'($signed(cen1[i])) - 25'($signed(cfg.c0[i]));
      s1_nxt.d[i] = 25'($signed(vel1[i])) - 25'($signed(cfg.v0[i]));
      sum_c[i]    = 25'($signed(cen1[i])) + 25'($signed(cfg.c0[i]));
      s1_nxt.mid[i] = sum_c[i][24:1];
    end
    s1_nxt.rs = {1'b0, cfg.r0} + {1'b0, in_data.cand_radius};
  end

  // Squares and dot products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ev[i]  = $signed(s1_r.e[i]);
      dv[i]  = $signed(s1_r.d[i]);
      pee[i] = ev[i] * ev[i];
      pdd[i] = dv[i] * dv[i];
      ped[i] = ev[i] * dv[i];
      s2_nxt.ee[i] = pee[i];
      s2_nxt.dd[i] = pdd[i];
      s2_nxt.ed[i] = ped[i];
    end
    s2_nxt.rr = s1_r.rs * s1_r.rs;
    s2_nxt.g  = s1_r;
  end

  // A, B, C, R and the moving-case test
  always_comb begin
    s3_nxt.a = s2_r.dd[0] + s2_r.dd[1] + s2_r.dd[2];
    s3_nxt.c = s2_r.ee[0] + s2_r.ee[1] + s2_r.ee[2];
    bsum = $signed(s2_r.ed[0]) + $signed(s2_r.ed[1]) + $signed(s2_r.ed[2]);
    nb   = -bsum;
    s3_nxt.r    = s2_r.rr;
    s3_nxt.ub   = nb[49:0];
    s3_nxt.mv   = (s3_nxt.a != '0) && (bsum <= 51'sd0);
    s3_nxt.cle  = s3_nxt.c <= {2'b0, s2_r.rr};
    s3_nxt.dpos = s3_nxt.cle ? '0 : s3_nxt.c - {2'b0, s2_r.rr};
    s3_nxt.tt   = cfg.tmax * cfg.tmax;
    s3_nxt.g    = s2_r.g;
  end

  // Partial products, each at most 32 x 25 bits
  always_comb begin
    s4_nxt.ta_l  = cfg.tmax * s3_r.a[24:0];
    s4_nxt.ta_h  = cfg.tmax * s3_r.a[49:25];
    s4_nxt.tta_l = s3_r.tt * s3_r.a[24:0];
    s4_nxt.tta_h = s3_r.tt * s3_r.a[49:25];
    s4_nxt.tu_l  = cfg.tmax * s3_r.ub[24:0];
    s4_nxt.tu_h  = cfg.tmax * s3_r.ub[49:25];
    s4_nxt.bb_hh = s3_r.ub[49:25] * s3_r.ub[49:25];
    s4_nxt.bb_hl = s3_r.ub[49:25] * s3_r.ub[24:0];
    s4_nxt.bb_ll = s3_r.ub[24:0] * s3_r.ub[24:0];
    s4_nxt.ac_hh = s3_r.a[49:25] * s3_r.dpos[49:25];
    s4_nxt.ac_hl = s3_r.a[49:25] * s3_r.dpos[24:0];
    s4_nxt.ac_lh = s3_r.a[24:0] * s3_r.dpos[49:25];
    s4_nxt.ac_ll = s3_r.a[24:0] * s3_r.dpos[24:0];
    s4_nxt.a   = s3_r.a;
    s4_nxt.c   = s3_r.c;
    s4_nxt.r   = s3_r.r;
    s4_nxt.ub  = s3_r.ub;
    s4_nxt.cle = s3_r.cle;
    s4_nxt.mv  = s3_r.mv;
    s4_nxt.g   = s3_r.g;
  end

  // Assemble wide products
  always_comb begin
    ac_mid = {1'b0, s4_r.ac_hl} + {1'b0, s4_r.ac_lh};
    s5_nxt.ta  = {s4_r.ta_h, 25'b0} + {25'b0, s4_r.ta_l};
    s5_nxt.tta = {s4_r.tta_h, 25'b0} + {25'b0, s4_r.tta_l};
    s5_nxt.tu  = {s4_r.tu_h, 25'b0} + {25'b0, s4_r.tu_l};
    s5_nxt.bb  = {1'b0, s4_r.bb_hh, 50'b0} + {25'b0, s4_r.bb_hl, 26'b0}
               + {51'b0, s4_r.bb_ll};
    s5_nxt.ac  = {1'b0, s4_r.ac_hh, 50'b0} + {25'b0, ac_mid, 25'b0}
               + {51'b0, s4_r.ac_ll};
    s5_nxt.a   = s4_r.a;
    s5_nxt.c   = s4_r.c;
    s5_nxt.r   = s4_r.r;
    s5_nxt.ub  = s4_r.ub;
    s5_nxt.cle = s4_r.cle;
    s5_nxt.mv  = s4_r.mv;
    s5_nxt.g   = s4_r.g;
  end

  // Reach terms and discriminant
  always_comb begin
    s6_nxt.reach1 = {8'b0, s5_r.ub, 8'b0} <= s5_r.ta;
    s6_nxt.lhs    = {2'b0, s5_r.tta} + {18'b0, s5_r.c, 16'b0};
    s6_nxt.rhs    = {20'b0, s5_r.r, 16'b0} + {9'b0, s5_r.tu, 9'b0};
    s6_nxt.acle   = s5_r.ac <= s5_r.bb;
    s6_nxt.disc   = s5_r.bb - s5_r.ac;
    s6_nxt.a      = s5_r.a;
    s6_nxt.ub     = s5_r.ub;
    s6_nxt.cle    = s5_r.cle;
    s6_nxt.mv     = s5_r.mv;
    s6_nxt.g      = s5_r.g;
  end

  // Classify
  always_comb begin
    reach2 = s6_r.lhs <= s6_r.rhs;
    if (s6_r.mv) begin
      if (!(s6_r.reach1 || reach2)) begin
        s7_nxt.kind = K_MISS;
      end else if (s6_r.cle) begin
        s7_nxt.kind = K_OVER;
      end else if (s6_r.acle) begin
        s7_nxt.kind = K_MOVE;
      end else begin
        s7_nxt.kind = K_MISS;
      end
    end else begin
      s7_nxt.kind = s6_r.cle ? K_OVER : K_MISS;
    end
    s7_nxt.ub   = s6_r.ub;
    s7_nxt.a    = s6_r.a;
    s7_nxt.disc = s6_r.disc;
    s7_nxt.e    = s6_r.g.e;
    s7_nxt.d    = s6_r.g.d;
    s7_nxt.mid  = s6_r.g.mid;
    s7_nxt.rs   = s6_r.g.rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
    end
  end

endmodule

### src/msfc_queue.sv
module msfc_queue #(
  parameter int DEPTH = msfc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  msfc_pkg::cls_t push_data,
  output logic           full,
  input  logic           pop,
  output msfc_pkg::cls_t head,
  output logic           empty
);
  import msfc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign head  = mem_r[rp_r];
  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

### src/msfc_back.sv
module msfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  msfc_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  msfc_pkg::cls_t     q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output msfc_pkg::out_item_t out_data
);
  import msfc_pkg::*;

  localparam int NS = SQ_BITS + 1 + DV_BITS;

  typedef struct packed {
    kind_t            kind;
    logic [49:0]      ub;
    logic [49:0]      a;
    logic [2:0][24:0] e;
    logic [2:0][24:0] d;
    logic [2:0][23:0] mid;
    logic [23:0]      rs;
    logic             rsz;
    logic [101:0]     rem;
    logic [50:0]      root;
    logic [39:0]      krem;
    logic [16:0]      kq;
    logic [57:0]      drem;
    logic [16:0]      q;
    logic             big;
  } bk_t;

  typedef struct packed {
    kind_t            kind;
    logic [15:0]      tm;
    logic [16:0]      k;
    logic [2:0][24:0] e;
    logic [2:0][24:0] d;
    logic [2:0][23:0] mid;
  } t1_t;

  typedef struct packed {
    kind_t            kind;
    logic [15:0]      tm;
    logic [16:0]      k;
    logic [2:0][24:0] e;
    logic [2:0][41:0] pw;
    logic [2:0][40:0] pv;
    logic [2:0][23:0] mid;
  } t2_t;

  typedef struct packed {
    kind_t            kind;
    logic [15:0]      tm;
    logic [16:0]      k;
    logic [2:0][42:0] w;
    logic [2:0][40:0] pv;
    logic [2:0][23:0] mid;
  } t3_t;

  typedef struct packed {
    kind_t            kind;
    logic [15:0]      tm;
    logic [2:0][38:0] kwl;
    logic [2:0][37:0] kwh;
    logic [2:0][40:0] pv;
    logic [2:0][23:0] mid;
  } t4_t;

  function automatic bk_t sq_step(bk_t x, int sb);
    logic [101:0] trial;
    bk_t          y;
    y     = x;
    trial = ({51'b0, x.root} << (sb + 1)) | (102'd1 << (2 * sb));
    if (x.rem >= trial) begin
      y.rem  = x.rem - trial;
      y.root = x.root | (51'd1 << sb);
    end
    return y;
  endfunction

  function automatic bk_t k_step(bk_t x, int kb);
    logic [39:0] sub;
    bk_t         y;
    y   = x;
    sub = {16'b0, x.rs} << kb;
    if (x.krem >= sub) begin
      y.krem = x.krem - sub;
      y.kq   = x.kq | (17'd1 << kb);
    end
    return y;
  endfunction

  function automatic bk_t dv_step(bk_t x, int db);
    logic [66:0] sub;
    bk_t         y;
    y   = x;
    sub = {17'b0, x.a} << db;
    if ({9'b0, x.drem} >= sub) begin
      y.drem = x.drem - sub[57:0];
      y.q    = x.q | (17'd1 << db);
    end
    return y;
  endfunction

  function automatic bk_t num_step(bk_t x);
    logic [49:0] diff;
    bk_t         y;
    y      = x;
    diff   = x.ub - x.root[49:0];
    y.drem = {diff, 8'b0};
    y.big  = {9'b0, diff, 8'b0} >= {x.a, 17'b0};
    y.q    = '0;
    return y;
  endfunction

  logic          en;
  bk_t           st_head;
  bk_t           st_in  [NS];
  bk_t           st_nxt [NS];
  bk_t           st_r   [NS];
  logic [NS-1:0] sv_r;
  t1_t           t1_r, t1_nxt;
  t2_t           t2_r, t2_nxt;
  t3_t           t3_r, t3_nxt;
  t4_t           t4_r, t4_nxt;
  logic [3:0]    tv_r;
  out_item_t     out_r, out_nxt;
  logic          out_valid_r;

  logic signed [63:0] acc [3];
  logic signed [39:0] fl [3];
  logic signed [23:0] pt [3];

  assign en        = !out_valid_r || !out_stall;
  assign pop       = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    st_head.kind = q_head.kind;
    st_head.ub   = q_head.ub;
    st_head.a    = q_head.a;
    st_head.e    = q_head.e;
    st_head.d    = q_head.d;
    st_head.mid  = q_head.mid;
    st_head.rs   = q_head.rs;
    st_head.rsz  = q_head.rs == '0;
    st_head.rem  = {1'b0, q_head.disc};
    st_head.root = '0;
    st_head.krem = {1'b0, cfg.r0, 16'b0};
    st_head.kq   = '0;
    st_head.drem = '0;
    st_head.q    = '0;
    st_head.big  = 1'b0;
  end

  for (genvar j = 0; j < NS; j++) begin : g_stg
    if (j > 0) begin : g_link
      assign st_in[j] = st_r[j-1];
    end else begin : g_head
      assign st_in[j] = st_head;
    end
    if (j < SQ_BITS && j < K_BITS) begin : g_sqk
      assign st_nxt[j] = k_step(sq_step(st_in[j], SQ_BITS - 1 - j), K_BITS - 1 - j);
    end else if (j < SQ_BITS) begin : g_sq
      assign st_nxt[j] = sq_step(st_in[j], SQ_BITS - 1 - j);
    end else if (j == SQ_BITS) begin : g_num
      assign st_nxt[j] = num_step(st_in[j]);
    end else begin : g_dv
      assign st_nxt[j] = dv_step(st_in[j], NS - 1 - j);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  // Clamp time, settle the radius ratio
  always_comb begin
    if (st_r[NS-1].big || st_r[NS-1].q > {1'b0, cfg.tmax}) begin
      t1_nxt.tm = cfg.tmax;
    end else begin
      t1_nxt.tm = st_r[NS-1].q[15:0];
    end
    t1_nxt.k    = st_r[NS-1].rsz ? '0 : st_r[NS-1].kq;
    t1_nxt.kind = st_r[NS-1].kind;
    t1_nxt.e    = st_r[NS-1].e;
    t1_nxt.d    = st_r[NS-1].d;
    t1_nxt.mid  = st_r[NS-1].mid;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t2_nxt.pw[i] = $signed({1'b0, t1_r.tm}) * $signed(t1_r.d[i]);
      t2_nxt.pv[i] = $signed({1'b0, t1_r.tm}) * $signed(cfg.v0[i]);
    end
    t2_nxt.kind = t1_r.kind;
    t2_nxt.tm   = t1_r.tm;
    t2_nxt.k    = t1_r.k;
    t2_nxt.e    = t1_r.e;
    t2_nxt.mid  = t1_r.mid;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t3_nxt.w[i] = $signed({t2_r.e[i], 8'b0}) + $signed(t2_r.pw[i]);
    end
    t3_nxt.kind = t2_r.kind;
    t3_nxt.tm   = t2_r.tm;
    t3_nxt.k    = t2_r.k;
    t3_nxt.pv   = t2_r.pv;
    t3_nxt.mid  = t2_r.mid;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t4_nxt.kwl[i] = t3_r.k * t3_r.w[i][21:0];
      t4_nxt.kwh[i] = $signed({1'b0, t3_r.k}) * $signed(t3_r.w[i][42:22]);
    end
    t4_nxt.kind = t3_r.kind;
    t4_nxt.tm   = t3_r.tm;
    t4_nxt.pv   = t3_r.pv;
    t4_nxt.mid  = t3_r.mid;
  end

  // Sum the point terms, floor, saturate, pick by class
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = $signed({cfg.c0[i], 24'b0}) + $signed({t4_r.pv[i], 16'b0})
             + $signed({t4_r.kwh[i], 22'b0}) + $signed({25'b0, t4_r.kwl[i]});
      fl[i]  = acc[i][63:24];
      if (fl[i] > 40'sd8388607) begin
        pt[i] = 24'sh7fffff;
      end else if (fl[i] < -40'sd8388608) begin
        pt[i] = 24'sh800000;
      end else begin
        pt[i] = fl[i][23:0];
      end
    end
    case (t4_r.kind)
      K_MOVE: begin
        out_nxt.hit          = 1'b1;
        out_nxt.contact_time = t4_r.tm;
        out_nxt.contact_x    = pt[0];
        out_nxt.contact_y    = pt[1];
        out_nxt.contact_z    = pt[2];
      end
      K_OVER: begin
        out_nxt.hit          = 1'b1;
        out_nxt.contact_time = '0;
        out_nxt.contact_x    = t4_r.mid[0];
        out_nxt.contact_y    = t4_r.mid[1];
        out_nxt.contact_z    = t4_r.mid[2];
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= '0;
      tv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sv_r        <= {sv_r[NS-2:0], !q_empty};
      tv_r        <= {tv_r[2:0], sv_r[NS-1]};
      out_valid_r <= tv_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= t1_nxt;
      t2_r  <= t2_nxt;
      t3_r  <= t3_nxt;
      t4_r  <= t4_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

### src/moving_sphere_first_contact.sv
// Moving sphere against moving sphere, first contact test.
// The reference sphere (centre, radius, velocity) and the end of the searched
// time window sit in eight registers written over the cfg_ port; write them
// only while no word is in flight. Each candidate word on the in_ channel gives
// exactly one result word on the out_ channel, in order: hit flag, first
// contact time (Q8.8) and contact point (Q12.12, saturated), zeros on a miss.
// Both channels move a word on a clock edge with valid high and stall low.
// Throughput is one word per cycle while neither channel stalls. From the
// accepting edge to out_valid a word passes 7 classifier stages, the queue,
// 51 square-root steps, one numerator stage, 17 divider steps, 4 contact-point
// stages and the output register. Square root and divide are one bit per stage.
// A stall on out_ freezes the solver pipe and its output register; the queue
// keeps filling, and in_stall rises only when the queue is full and the last
// classifier stage holds a word. Reset (synchronous, active low) empties both
// pipes and the queue and loads the registers: all zero, window end 1.0.
module moving_sphere_first_contact #(
  parameter int QDEPTH = msfc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  msfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output msfc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [23:0]         cfg_wdata
);
  import msfc_pkg::*;

  cfg_t cfg_r;
  logic push, q_full, q_empty, pop;
  cls_t push_data, q_head;

  // Register file: hold values between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c0   <= '0;
      cfg_r.r0   <= '0;
      cfg_r.v0   <= '0;
      cfg_r.tmax <= TMAX_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_CX:   cfg_r.c0[0] <= cfg_wdata;
        REG_CY:   cfg_r.c0[1] <= cfg_wdata;
        REG_CZ:   cfg_r.c0[2] <= cfg_wdata;
        REG_RAD:  cfg_r.r0    <= cfg_wdata[22:0];
        REG_VX:   cfg_r.v0[0] <= cfg_wdata;
        REG_VY:   cfg_r.v0[1] <= cfg_wdata;
        REG_VZ:   cfg_r.v0[2] <= cfg_wdata;
        REG_TMAX: cfg_r.tmax  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Classifier: A, B, C, R, reach and overlap tests
  msfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Decouple the two pipes
  msfc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Solver: square root, time divide, contact point
  msfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### src/msfc_chk.sv
module msfc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input msfc_pkg::out_item_t out_data
);
  import msfc_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // A miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.contact_time == '0 && out_data.contact_x == '0 &&
      out_data.contact_y == '0 && out_data.contact_z == '0)
    else $error("miss word with nonzero fields");

  // Reset drains the pipes and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipes not cleared by reset");

endmodule

bind moving_sphere_first_contact msfc_chk u_msfc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
